// ----- rtl/interrupt_cause_and_beep_registers_macros.svh -----
// assertion macros for the interrupt cause and beep register block
// used by the checker module; no other dependencies
`ifndef INTERRUPT_CAUSE_AND_BEEP_REGISTERS_MACROS_SVH
`define INTERRUPT_CAUSE_AND_BEEP_REGISTERS_MACROS_SVH

// concurrent assertion, masked while reset is asserted
`define ICBR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// concurrent assertion that also holds through reset
`define ICBR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ----- rtl/icbr_pkg.sv -----
// shared types and constants for the interrupt cause and beep register block
// no dependencies
package icbr_pkg;

    // command codes carried with each input item
    typedef enum logic [2:0] {
        CMD_READ         = 3'd0,
        CMD_WRITE        = 3'd1,
        CMD_TICK         = 3'd2,
        CMD_DISK_DONE    = 3'd3,
        CMD_PRINTER_DONE = 3'd4,
        CMD_KEY_EVENT    = 3'd5
    } t_cmd;

    // configuration register indexes
    typedef enum logic {
        CFG_TIMER_PERIOD = 1'b0,
        CFG_BEEP_LENGTH  = 1'b1
    } t_cfg_index;

    localparam int CFG_DATA_W   = 18;
    localparam int TIMER_W      = 12;
    localparam int BEEP_W       = 18;

    // decoded bus addresses
    localparam logic [15:0] ADDR_KEY_HI  = 16'hFD00;
    localparam logic [15:0] ADDR_KEY_LO  = 16'hFD01;
    localparam logic [15:0] ADDR_ENABLES = 16'hFD02;
    localparam logic [15:0] ADDR_CAUSE   = 16'hFD03;
    localparam logic [15:0] ADDR_ROM     = 16'hFD0F;

    // register reset values
    localparam logic [TIMER_W-1:0] TIMER_PERIOD_RST = 12'd2034;
    localparam logic [BEEP_W-1:0]  BEEP_LENGTH_RST  = 18'd205000;

    // enable register bit positions
    localparam int EN_KEY     = 0;
    localparam int EN_PRINTER = 1;
    localparam int EN_TIMER   = 2;
    localparam int EN_DISK    = 4;

    // beep control bits of the 0xFD03 write
    localparam int BEEP_SPEAKER = 0;
    localparam int BEEP_ONESHOT = 6;
    localparam int BEEP_CONT    = 7;

    // one result item
    typedef struct packed {
        logic [7:0] read_data;
        logic       decoded;
        logic [3:0] cause_pending;
        logic [7:0] enable_bits;
        logic       beep_on;
        logic       speaker_on;
        logic       basic_rom_on;
    } t_result;

endpackage

// ----- rtl/icbr_core.sv -----
// state registers, address decode and result logic of the system i/o block
// depends on icbr_pkg
module icbr_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_index,
    input  logic [icbr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_accept,
    input  logic [2:0]                      i_cmd,
    input  logic [15:0]                     i_address,
    input  logic [7:0]                      i_write_data,
    input  logic [8:0]                      i_key_code,
    input  logic [4:0]                      i_other_irq_levels,
    output icbr_pkg::t_result               o_result
);

    // configuration
    logic [icbr_pkg::TIMER_W-1:0] r_timer_period;
    logic [icbr_pkg::BEEP_W-1:0]  r_beep_length;

    // block state and next values
    logic                         r_key_req,   n_key_req;
    logic                         r_prn_req,   n_prn_req;
    logic                         r_tmr_req,   n_tmr_req;
    logic                         r_disk_req,  n_disk_req;
    logic [7:0]                   r_enables,   n_enables;
    logic                         r_beep_on,   n_beep_on;
    logic                         r_speaker,   n_speaker;
    logic                         r_oneshot,   n_oneshot;
    logic [icbr_pkg::BEEP_W-1:0]  r_beep_cnt,  n_beep_cnt;
    logic [icbr_pkg::TIMER_W-1:0] r_tmr_cnt,   n_tmr_cnt;
    logic                         r_tmr_long,  n_tmr_long;
    logic                         r_rom,       n_rom;

    icbr_pkg::t_cmd     cmd;
    icbr_pkg::t_cfg_index cfg_idx;
    logic               others_any;
    logic [3:0]         cause_now;
    logic               tmr_expire;
    logic [7:0]         rd;
    logic               dec;

    assign cmd        = icbr_pkg::t_cmd'(i_cmd);
    assign cfg_idx    = icbr_pkg::t_cfg_index'(i_cfg_index);
    assign others_any = |i_other_irq_levels;

    // pending causes before this item's update
    assign cause_now = {r_disk_req | others_any, r_tmr_req, r_prn_req,
                        r_key_req & r_enables[icbr_pkg::EN_KEY]};

    // timer expires at zero in the long phase, at one in the short phase
    assign tmr_expire = r_tmr_long ? (r_tmr_cnt == '0)
                                   : (r_tmr_cnt <= {{(icbr_pkg::TIMER_W-1){1'b0}}, 1'b1});

    // command decode and next state
    always_comb begin
        n_key_req   = r_key_req;
        n_prn_req   = r_prn_req;
        n_tmr_req   = r_tmr_req;
        n_disk_req  = r_disk_req;
        n_enables   = r_enables;
        n_beep_on   = r_beep_on;
        n_speaker   = r_speaker;
        n_oneshot   = r_oneshot;
        n_beep_cnt  = r_beep_cnt;
        n_tmr_cnt   = r_tmr_cnt;
        n_tmr_long  = r_tmr_long;
        n_rom       = r_rom;
        rd          = 8'h00;
        dec         = 1'b0;
        unique case (cmd)
            icbr_pkg::CMD_READ: begin
                case (i_address)
                    icbr_pkg::ADDR_KEY_HI: begin
                        dec = 1'b1;
                        rd  = i_key_code[8] ? 8'hFF : 8'h7F;
                    end
                    icbr_pkg::ADDR_KEY_LO: begin
                        dec       = 1'b1;
                        rd        = i_key_code[7:0];
                        n_key_req = 1'b0;
                    end
                    icbr_pkg::ADDR_CAUSE: begin
                        dec       = 1'b1;
                        rd        = ~{4'h0, cause_now};
                        n_prn_req = 1'b0;
                        n_tmr_req = 1'b0;
                    end
                    icbr_pkg::ADDR_ROM: begin
                        dec   = 1'b1;
                        rd    = 8'hFF;
                        n_rom = 1'b1;
                    end
                    default: ;
                endcase
            end
            icbr_pkg::CMD_WRITE: begin
                case (i_address)
                    icbr_pkg::ADDR_ENABLES: begin
                        dec       = 1'b1;
                        n_enables = i_write_data;
                    end
                    icbr_pkg::ADDR_CAUSE: begin
                        dec       = 1'b1;
                        n_speaker = i_write_data[icbr_pkg::BEEP_SPEAKER];
                        if (i_write_data[icbr_pkg::BEEP_ONESHOT]) begin
                            n_beep_on   = 1'b1;
                            n_oneshot   = 1'b1;
                            n_beep_cnt  = r_beep_length;
                        end else begin
                            n_beep_on = i_write_data[icbr_pkg::BEEP_CONT];
                        end
                    end
                    icbr_pkg::ADDR_ROM: begin
                        dec   = 1'b1;
                        n_rom = 1'b0;
                    end
                    default: ;
                endcase
            end
            icbr_pkg::CMD_TICK: begin
                // periodic timer, alternating short and long periods
                if (tmr_expire) begin
                    n_tmr_req  = r_enables[icbr_pkg::EN_TIMER];
                    n_tmr_long = ~r_tmr_long;
                    n_tmr_cnt  = (r_timer_period == '0)
                               ? {{(icbr_pkg::TIMER_W-1){1'b0}}, 1'b1} : r_timer_period;
                end else begin
                    n_tmr_cnt = r_tmr_cnt - 1'b1;
                end
                // one-shot beep countdown
                if (r_oneshot) begin
                    if (r_beep_cnt <= {{(icbr_pkg::BEEP_W-1){1'b0}}, 1'b1}) begin
                        n_oneshot   = 1'b0;
                        n_beep_on   = 1'b0;
                        n_beep_cnt  = '0;
                    end else begin
                        n_beep_cnt = r_beep_cnt - 1'b1;
                    end
                end
            end
            icbr_pkg::CMD_DISK_DONE: begin
                if (r_enables[icbr_pkg::EN_DISK]) n_disk_req = 1'b1;
            end
            icbr_pkg::CMD_PRINTER_DONE: begin
                if (r_enables[icbr_pkg::EN_PRINTER]) n_prn_req = 1'b1;
            end
            icbr_pkg::CMD_KEY_EVENT: begin
                n_key_req = 1'b1;
            end
            default: ;
        endcase
    end

    // result item from the updated state
    always_comb begin
        o_result.read_data     = rd;
        o_result.decoded       = dec;
        o_result.cause_pending = {n_disk_req | others_any, n_tmr_req, n_prn_req,
                                  n_key_req & n_enables[icbr_pkg::EN_KEY]};
        o_result.enable_bits   = n_enables;
        o_result.beep_on       = n_beep_on;
        o_result.speaker_on    = n_speaker;
        o_result.basic_rom_on  = n_rom;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer_period <= icbr_pkg::TIMER_PERIOD_RST;
            r_beep_length  <= icbr_pkg::BEEP_LENGTH_RST;
        end else if (i_cfg_we) begin
            unique case (cfg_idx)
                icbr_pkg::CFG_TIMER_PERIOD: r_timer_period <= i_cfg_data[icbr_pkg::TIMER_W-1:0];
                icbr_pkg::CFG_BEEP_LENGTH:  r_beep_length  <= i_cfg_data[icbr_pkg::BEEP_W-1:0];
                default: ;
            endcase
        end
    end

    // state update on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_req   <= 1'b0;
            r_prn_req   <= 1'b0;
            r_tmr_req   <= 1'b0;
            r_disk_req  <= 1'b0;
            r_enables   <= 8'h00;
            r_beep_on   <= 1'b0;
            r_speaker   <= 1'b0;
            r_oneshot   <= 1'b0;
            r_beep_cnt  <= '0;
            r_tmr_cnt   <= icbr_pkg::TIMER_PERIOD_RST;
            r_tmr_long  <= 1'b0;
            r_rom       <= 1'b1;
        end else if (i_accept) begin
            r_key_req   <= n_key_req;
            r_prn_req   <= n_prn_req;
            r_tmr_req   <= n_tmr_req;
            r_disk_req  <= n_disk_req;
            r_enables   <= n_enables;
            r_beep_on   <= n_beep_on;
            r_speaker   <= n_speaker;
            r_oneshot   <= n_oneshot;
            r_beep_cnt  <= n_beep_cnt;
            r_tmr_cnt   <= n_tmr_cnt;
            r_tmr_long  <= n_tmr_long;
            r_rom       <= n_rom;
        end
    end

endmodule

// ----- rtl/icbr_obuf.sv -----
// two-entry output buffer: result register plus skid register
// depends on icbr_pkg
module icbr_obuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  icbr_pkg::t_result i_result,
    output logic              o_full,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output icbr_pkg::t_result o_result
);

    logic              r_out_valid, n_out_valid;
    logic              r_skid_valid, n_skid_valid;
    icbr_pkg::t_result r_out, n_out;
    icbr_pkg::t_result r_skid, n_skid;
    logic              out_free;

    // output slot frees when empty or its transfer completes
    assign out_free = !r_out_valid || !i_out_stall;

    // slot movement
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (out_free) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else if (i_push) begin
                n_out       = i_result;
                n_out_valid = 1'b1;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (i_push) begin
            n_skid       = i_result;
            n_skid_valid = 1'b1;
        end
    end

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_full      = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule

// ----- rtl/interrupt_cause_and_beep_registers.sv -----
// top level of the interrupt cause, enable and beep register block
// depends on icbr_pkg, icbr_core and icbr_obuf
//
//  channel   handshake                 payload
//  input     i_in_valid / o_in_stall   i_cmd i_address i_write_data i_key_code
//                                      i_other_irq_levels
//  output    o_out_valid / i_out_stall o_read_data o_decoded o_cause_pending
//                                      o_enable_bits o_beep_on o_speaker_on
//                                      o_basic_rom_on
//  config    i_cfg_we                  i_cfg_index i_cfg_data
//
// one item per cycle while o_in_stall is low; its result is registered in the output buffer
// state updates and decode are one level of logic ahead of the result register
// i_rst_n is synchronous; after reset the timer counts the short period
// a two-entry output buffer lets one more input transfer through while the
// output is stalled; o_in_stall rises only when both entries hold results
module interrupt_cause_and_beep_registers (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [17:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_cmd,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_write_data,
    input  logic [8:0]  i_key_code,
    input  logic [4:0]  i_other_irq_levels,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_read_data,
    output logic        o_decoded,
    output logic [3:0]  o_cause_pending,
    output logic [7:0]  o_enable_bits,
    output logic        o_beep_on,
    output logic        o_speaker_on,
    output logic        o_basic_rom_on
);

    logic              accept;
    logic              full;
    icbr_pkg::t_result core_result;
    icbr_pkg::t_result out_result;

    // input transfer
    assign accept     = i_in_valid && !full;
    assign o_in_stall = full;

    icbr_core u_core (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_accept           (accept),
        .i_cmd              (i_cmd),
        .i_address          (i_address),
        .i_write_data       (i_write_data),
        .i_key_code         (i_key_code),
        .i_other_irq_levels (i_other_irq_levels),
        .o_result           (core_result)
    );

    icbr_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (accept),
        .i_result    (core_result),
        .o_full      (full),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (out_result)
    );

    // result fields
    assign o_read_data     = out_result.read_data;
    assign o_decoded       = out_result.decoded;
    assign o_cause_pending = out_result.cause_pending;
    assign o_enable_bits   = out_result.enable_bits;
    assign o_beep_on       = out_result.beep_on;
    assign o_speaker_on    = out_result.speaker_on;
    assign o_basic_rom_on  = out_result.basic_rom_on;

endmodule

// ----- rtl/icbr_checker.sv -----
// port-level checks for the interrupt cause and beep register block
// depends on interrupt_cause_and_beep_registers_macros.svh; bound to the top level
`include "interrupt_cause_and_beep_registers_macros.svh"

module icbr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [7:0]  o_read_data,
    input logic        o_decoded,
    input logic [3:0]  o_cause_pending,
    input logic [7:0]  o_enable_bits,
    input logic        o_beep_on,
    input logic        o_speaker_on,
    input logic        o_basic_rom_on
);

    logic [23:0] out_bits;

    // all result fields side by side
    assign out_bits = {o_read_data, o_decoded, o_cause_pending, o_enable_bits,
                       o_beep_on, o_speaker_on, o_basic_rom_on};

    // a stalled result holds until its transfer
    `ICBR_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(out_bits), "stalled result changed")

    // reads and writes outside the block return zero
    `ICBR_ASSERT(a_undecoded_zero, i_clk, i_rst_n, o_out_valid && !o_decoded |-> o_read_data == 8'h00, "read data without decode")

    // input stalls only while an undelivered result is shown
    `ICBR_ASSERT(a_stall_needs_result, i_clk, i_rst_n, o_in_stall |-> o_out_valid, "input stall with empty output")

    // reset empties the output buffer
    `ICBR_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid && !o_in_stall, "output not empty after reset")

endmodule

bind interrupt_cause_and_beep_registers icbr_checker u_icbr_checker (.*);

// ----- tb/interrupt_cause_and_beep_registers_tb.sv -----
// self-checking testbench for the interrupt cause, enable and beep register block
// depends on icbr_pkg and interrupt_cause_and_beep_registers; a local predictor
// tracks requests, enables, beeper, timer and rom switch and checks every result
`timescale 1ns / 1ps

module interrupt_cause_and_beep_registers_tb;

    // command codes the block leaves without effect
    localparam logic [2:0] CMD_SPARE_A = 3'd6;
    localparam logic [2:0] CMD_SPARE_B = 3'd7;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] addr;
        logic [7:0]  wdata;
        logic [8:0]  key;
        logic [4:0]  others;
    } t_io_item;

    // dut inputs, all known from time zero
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [17:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [2:0]  i_cmd = '0;
    logic [15:0] i_address = '0;
    logic [7:0]  i_write_data = '0;
    logic [8:0]  i_key_code = '0;
    logic [4:0]  i_other_irq_levels = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_read_data;
    logic        o_decoded;
    logic [3:0]  o_cause_pending;
    logic [7:0]  o_enable_bits;
    logic        o_beep_on;
    logic        o_speaker_on;
    logic        o_basic_rom_on;

    // predicted block state, starting at its reset values
    logic [icbr_pkg::TIMER_W-1:0] cfg_period = icbr_pkg::TIMER_PERIOD_RST;
    logic [icbr_pkg::BEEP_W-1:0]  cfg_beep   = icbr_pkg::BEEP_LENGTH_RST;
    logic               key_req    = 1'b0;
    logic               prn_req    = 1'b0;
    logic               tmr_req    = 1'b0;
    logic               dsk_req    = 1'b0;
    logic [7:0]         en_reg     = '0;
    logic               beep_snd   = 1'b0;
    logic               spk        = 1'b0;
    logic               oneshot    = 1'b0;
    logic [icbr_pkg::BEEP_W-1:0]  beep_cnt   = '0;
    logic [icbr_pkg::TIMER_W-1:0] tmr_cnt    = icbr_pkg::TIMER_PERIOD_RST;
    logic               tmr_long   = 1'b0;
    logic               rom_in     = 1'b1;

    t_io_item          stim_q[$];
    icbr_pkg::t_result io_results_due[$];
    int unsigned mismatches = 0;
    int unsigned in_gap = 0;
    int unsigned out_run = 0;
    bit          idle_on = 1'b1;

    interrupt_cause_and_beep_registers u_dut (.*);

    always #2 i_clk = ~i_clk;

    // generous watchdog
    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // pending cause bits, active high, in the bit order of the cause register
    function automatic logic [3:0] cause_now(input logic [4:0] lvl);
        return {dsk_req || (lvl != '0), tmr_req, prn_req,
                key_req && en_reg[icbr_pkg::EN_KEY]};
    endfunction

    // apply one transfer to the predicted state and return the result it yields
    function automatic icbr_pkg::t_result compute_io_result(input logic [2:0] cmd,
            input logic [15:0] addr, input logic [7:0] wdata,
            input logic [8:0] key, input logic [4:0] others);
        icbr_pkg::t_result res;
        res = '0;
        case (cmd)
            icbr_pkg::CMD_READ: begin
                if (addr == icbr_pkg::ADDR_KEY_HI) begin
                    res.decoded = 1'b1;
                    res.read_data = key[8] ? 8'hFF : 8'h7F;
                end else if (addr == icbr_pkg::ADDR_KEY_LO) begin
                    res.decoded = 1'b1;
                    res.read_data = key[7:0];
                    key_req = 1'b0;
                end else if (addr == icbr_pkg::ADDR_CAUSE) begin
                    res.decoded = 1'b1;
                    res.read_data = {4'hF, ~cause_now(others)};
                    prn_req = 1'b0;
                    tmr_req = 1'b0;
                end else if (addr == icbr_pkg::ADDR_ROM) begin
                    res.decoded = 1'b1;
                    res.read_data = 8'hFF;
                    rom_in = 1'b1;
                end
            end
            icbr_pkg::CMD_WRITE: begin
                if (addr == icbr_pkg::ADDR_ENABLES) begin
                    res.decoded = 1'b1;
                    en_reg = wdata;
                end else if (addr == icbr_pkg::ADDR_CAUSE) begin
                    res.decoded = 1'b1;
                    spk = wdata[icbr_pkg::BEEP_SPEAKER];
                    if (wdata[icbr_pkg::BEEP_ONESHOT]) begin
                        beep_snd = 1'b1;
                        oneshot = 1'b1;
                        beep_cnt = cfg_beep;
                    end else begin
                        beep_snd = wdata[icbr_pkg::BEEP_CONT];
                    end
                end else if (addr == icbr_pkg::ADDR_ROM) begin
                    res.decoded = 1'b1;
                    rom_in = 1'b0;
                end
            end
            icbr_pkg::CMD_TICK: begin
                // periods alternate short and short plus one
                if (tmr_cnt > {11'b0, ~tmr_long}) begin
                    tmr_cnt = tmr_cnt - 1'b1;
                end else begin
                    tmr_req = en_reg[icbr_pkg::EN_TIMER];
                    tmr_long = ~tmr_long;
                    tmr_cnt = (cfg_period == '0) ? icbr_pkg::TIMER_W'(1) : cfg_period;
                end
                if (oneshot) begin
                    if (beep_cnt <= icbr_pkg::BEEP_W'(1)) begin
                        oneshot = 1'b0;
                        beep_snd = 1'b0;
                        beep_cnt = '0;
                    end else begin
                        beep_cnt = beep_cnt - 1'b1;
                    end
                end
            end
            icbr_pkg::CMD_DISK_DONE: begin
                if (en_reg[icbr_pkg::EN_DISK]) dsk_req = 1'b1;
            end
            icbr_pkg::CMD_PRINTER_DONE: begin
                if (en_reg[icbr_pkg::EN_PRINTER]) prn_req = 1'b1;
            end
            icbr_pkg::CMD_KEY_EVENT: begin
                key_req = 1'b1;
            end
            default: ;
        endcase
        res.cause_pending = cause_now(others);
        res.enable_bits   = en_reg;
        res.beep_on       = beep_snd;
        res.speaker_on    = spk;
        res.basic_rom_on  = rom_in;
        return res;
    endfunction

    // idle length: mostly none, sometimes short, rarely long
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    // random access, biased toward decoded addresses and ticks
    function automatic t_io_item rand_io_item();
        t_io_item it;
        int unsigned r;
        it.addr   = 16'($urandom);
        it.wdata  = 8'($urandom);
        it.key    = 9'($urandom);
        it.others = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'd0;
        r = $urandom_range(0, 99);
        if (r < 25) begin
            it.cmd = icbr_pkg::CMD_READ;
            case ($urandom_range(0, 4))
                0:       it.addr = icbr_pkg::ADDR_KEY_HI;
                1:       it.addr = icbr_pkg::ADDR_KEY_LO;
                4:       it.addr = icbr_pkg::ADDR_ROM;
                default: it.addr = icbr_pkg::ADDR_CAUSE;
            endcase
        end else if (r < 40) begin
            it.cmd = icbr_pkg::CMD_WRITE;
            case ($urandom_range(0, 4))
                0, 1:    it.addr = icbr_pkg::ADDR_ENABLES;
                4:       it.addr = icbr_pkg::ADDR_ROM;
                default: it.addr = icbr_pkg::ADDR_CAUSE;
            endcase
            if (it.addr == icbr_pkg::ADDR_CAUSE && $urandom_range(0, 3) != 0)
                it.wdata[icbr_pkg::BEEP_ONESHOT] = 1'b0;
        end else if (r < 75) begin
            it.cmd = icbr_pkg::CMD_TICK;
        end else if (r < 80) begin
            it.cmd = icbr_pkg::CMD_DISK_DONE;
        end else if (r < 86) begin
            it.cmd = icbr_pkg::CMD_PRINTER_DONE;
        end else if (r < 92) begin
            it.cmd = icbr_pkg::CMD_KEY_EVENT;
        end else begin
            // noise: any command, near-miss or random address
            it.cmd = 3'($urandom);
            if ($urandom_range(0, 1) == 0)
                it.addr = {icbr_pkg::ADDR_KEY_HI[15:4], 4'($urandom)};
        end
        return it;
    endfunction

    task automatic add_item(input logic [2:0] cmd, input logic [15:0] addr,
            input logic [7:0] wdata, input logic [8:0] key, input logic [4:0] others);
        stim_q.push_back('{cmd, addr, wdata, key, others});
    endtask

    // register write, only issued while the block is idle
    task automatic write_reg(input icbr_pkg::t_cfg_index idx,
            input logic [icbr_pkg::CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        if (idx == icbr_pkg::CFG_TIMER_PERIOD) cfg_period = val[icbr_pkg::TIMER_W-1:0];
        else cfg_beep = val[icbr_pkg::BEEP_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // wait until every queued transfer has gone through and been checked
    task automatic wait_drained();
        while (stim_q.size() != 0 || i_in_valid || io_results_due.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic compare_field(input string name, input int unsigned want,
            input int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        end
    endtask

    // input driver: holds a stalled transfer, otherwise idles or presents the next item
    always @(posedge i_clk) begin : driver
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                io_results_due.push_back(compute_io_result(i_cmd, i_address,
                    i_write_data, i_key_code, i_other_irq_levels));
            if (i_in_valid && o_in_stall) begin
                // keep the stalled transfer as it is
            end else if (in_gap != 0) begin
                in_gap <= in_gap - 1;
                i_in_valid <= 1'b0;
            end else if (stim_q.size() != 0) begin
                t_io_item it;
                it = stim_q.pop_front();
                i_cmd              <= it.cmd;
                i_address          <= it.addr;
                i_write_data       <= it.wdata;
                i_key_code         <= it.key;
                i_other_irq_levels <= it.others;
                i_in_valid         <= 1'b1;
                in_gap             <= pick_gap();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result monitor and output stall generator
    always @(posedge i_clk) begin : monitor
        icbr_pkg::t_result want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (io_results_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: result transfer with nothing expected", $time);
                end else begin
                    want = io_results_due.pop_front();
                    compare_field("read_data", want.read_data, o_read_data);
                    compare_field("decoded", want.decoded, o_decoded);
                    compare_field("cause_pending", want.cause_pending, o_cause_pending);
                    compare_field("enable_bits", want.enable_bits, o_enable_bits);
                    compare_field("beep_on", want.beep_on, o_beep_on);
                    compare_field("speaker_on", want.speaker_on, o_speaker_on);
                    compare_field("basic_rom_on", want.basic_rom_on, o_basic_rom_on);
                end
            end
            if (out_run != 0) begin
                out_run <= out_run - 1;
            end else if (!i_out_stall && idle_on && $urandom_range(0, 2) == 0) begin
                i_out_stall <= 1'b1;
                out_run <= pick_gap();
            end else begin
                i_out_stall <= 1'b0;
                out_run <= $urandom_range(0, 8);
            end
        end
    end

    // stimulus phases
    initial begin : stimulus
        logic [icbr_pkg::TIMER_W-1:0] periods[4];
        logic [icbr_pkg::BEEP_W-1:0]  lengths[4];
        periods = '{12'd1, 12'd0, 12'd7, 12'd4095};
        lengths = '{18'd1, 18'd0, 18'd20, 18'd262143};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: decoded and undecoded reads and writes, spare commands and a tick at reset settings
        add_item(icbr_pkg::CMD_READ, icbr_pkg::ADDR_KEY_HI, 8'h00, 9'h1FF, 5'd0);
        add_item(icbr_pkg::CMD_READ, icbr_pkg::ADDR_KEY_HI, 8'h00, 9'h0FF, 5'd0);
        add_item(icbr_pkg::CMD_READ, icbr_pkg::ADDR_KEY_LO, 8'h00, 9'h1A5, 5'd0);
        add_item(icbr_pkg::CMD_KEY_EVENT, 16'h0000, 8'h00, 9'h05A, 5'd0);
        add_item(icbr_pkg::CMD_READ, icbr_pkg::ADDR_CAUSE, 8'h00, 9'h000, 5'd0);
        add_item(icbr_pkg::CMD_WRITE, icbr_pkg::ADDR_ENABLES, 8'hFF, 9'h000, 5'd0);
        add_item(icbr_pkg::CMD_READ, icbr_pkg::ADDR_CAUSE, 8'h00, 9'h000, 5'h1F);
        add_item(icbr_pkg::CMD_READ, icbr_pkg::ADDR_KEY_LO, 8'h00, 9'h15A, 5'd0);
        add_item(icbr_pkg::CMD_PRINTER_DONE, 16'hFFFF, 8'hFF, 9'h1FF, 5'd0);
        add_item(icbr_pkg::CMD_DISK_DONE, 16'hFFFF, 8'hFF, 9'h1FF, 5'd0);
        add_item(icbr_pkg::CMD_READ, icbr_pkg::ADDR_CAUSE, 8'h00, 9'h000, 5'd0);
        add_item(icbr_pkg::CMD_WRITE, icbr_pkg::ADDR_CAUSE, 8'h01, 9'h000, 5'd0);
        add_item(icbr_pkg::CMD_WRITE, icbr_pkg::ADDR_CAUSE, 8'h80, 9'h000, 5'd0);
        add_item(icbr_pkg::CMD_WRITE, icbr_pkg::ADDR_CAUSE, 8'h40, 9'h000, 5'd0);
        add_item(icbr_pkg::CMD_WRITE, icbr_pkg::ADDR_CAUSE, 8'h00, 9'h000, 5'd0);
        add_item(icbr_pkg::CMD_WRITE, icbr_pkg::ADDR_ROM, 8'h00, 9'h000, 5'd0);
        add_item(icbr_pkg::CMD_READ, icbr_pkg::ADDR_ROM, 8'h00, 9'h000, 5'd0);
        add_item(icbr_pkg::CMD_WRITE, icbr_pkg::ADDR_ROM, 8'hFF, 9'h1FF, 5'h1F);
        add_item(icbr_pkg::CMD_READ, icbr_pkg::ADDR_ENABLES, 8'h00, 9'h1FF, 5'd0);
        add_item(icbr_pkg::CMD_WRITE, icbr_pkg::ADDR_KEY_HI, 8'hFF, 9'h000, 5'd0);
        add_item(icbr_pkg::CMD_WRITE, icbr_pkg::ADDR_KEY_LO, 8'hFF, 9'h000, 5'd0);
        add_item(icbr_pkg::CMD_READ, 16'hFFFF, 8'h00, 9'h000, 5'd0);
        add_item(icbr_pkg::CMD_READ, 16'h0000, 8'h00, 9'h000, 5'd0);
        add_item(CMD_SPARE_A, icbr_pkg::ADDR_CAUSE, 8'hFF, 9'h1FF, 5'd0);
        add_item(CMD_SPARE_B, icbr_pkg::ADDR_ROM, 8'hFF, 9'h1FF, 5'd0);
        add_item(icbr_pkg::CMD_TICK, 16'h0000, 8'h00, 9'h000, 5'd0);
        // masked disk and printer completions
        add_item(icbr_pkg::CMD_WRITE, icbr_pkg::ADDR_ENABLES, 8'h00, 9'h000, 5'd0);
        add_item(icbr_pkg::CMD_PRINTER_DONE, 16'h0000, 8'h00, 9'h000, 5'd0);
        add_item(icbr_pkg::CMD_DISK_DONE, 16'h0000, 8'h00, 9'h000, 5'd0);
        wait_drained();

        // back-to-back tick run so a short one-shot beep runs out
        write_reg(icbr_pkg::CFG_TIMER_PERIOD, 18'd3);
        write_reg(icbr_pkg::CFG_BEEP_LENGTH, 18'd5);
        idle_on = 1'b0;
        add_item(icbr_pkg::CMD_WRITE, icbr_pkg::ADDR_ENABLES, 8'h04, 9'h000, 5'd0);
        add_item(icbr_pkg::CMD_WRITE, icbr_pkg::ADDR_CAUSE, 8'h40, 9'h000, 5'd0);
        for (int i = 0; i < 46; i++) begin
            if (i % 12 == 0)
                add_item(icbr_pkg::CMD_READ, icbr_pkg::ADDR_CAUSE, 8'h00, 9'h000, 5'd0);
            else add_item(icbr_pkg::CMD_TICK, 16'h0000, 8'h00, 9'h000, 5'd0);
        end
        wait_drained();

        // random phases over several register settings
        for (int p = 0; p < 4; p++) begin
            write_reg(icbr_pkg::CFG_TIMER_PERIOD, icbr_pkg::CFG_DATA_W'(periods[p]));
            write_reg(icbr_pkg::CFG_BEEP_LENGTH, lengths[p]);
            idle_on = (p != 1);
            for (int i = 0; i < 80; i++) stim_q.push_back(rand_io_item());
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
